[src/dipc_pkg.sv]
// Shared codes, reset values and helper functions of the display idle power controller.
package dipc_pkg;

   // Power state codes
   localparam logic [2:0] ST_ACTIVE = 3'd0;
   localparam logic [2:0] ST_DIM    = 3'd1;
   localparam logic [2:0] ST_OFF    = 3'd2;
   localparam logic [2:0] ST_DOZE   = 3'd3;
   localparam logic [2:0] ST_SUSP   = 3'd4;

   // Item opcodes
   localparam logic [2:0] OP_TICK       = 3'd0;
   localparam logic [2:0] OP_ACTIVITY   = 3'd1;
   localparam logic [2:0] OP_SCREEN_OFF = 3'd2;
   localparam logic [2:0] OP_SCREEN_ON  = 3'd3;
   localparam logic [2:0] OP_SET_LEVEL  = 3'd4;
   localparam logic [2:0] OP_SET_LOCKS  = 3'd5;

   // Configuration register indexes
   localparam logic [2:0] REG_SCREEN_TIMEOUT = 3'd0;
   localparam logic [2:0] REG_DIM_TIMEOUT    = 3'd1;
   localparam logic [2:0] REG_DOZE_ENABLE    = 3'd2;
   localparam logic [2:0] REG_AUTO_SUSPEND   = 3'd3;
   localparam logic [2:0] REG_SUSPEND_DELAY  = 3'd4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Reset values of the configuration registers
   localparam logic [15:0] SCREEN_TIMEOUT_RST = 16'd30;
   localparam logic [15:0] DIM_TIMEOUT_RST    = 16'd20;
   localparam logic        DOZE_ENABLE_RST    = 1'b0;
   localparam logic        AUTO_SUSPEND_RST   = 1'b1;
   localparam logic [15:0] SUSPEND_DELAY_RST  = 16'd60;

   // Brightness constants
   localparam logic [6:0] LEVEL_RST     = 7'd80;
   localparam logic [6:0] LEVEL_DEFAULT = 7'd80;
   localparam logic [6:0] LEVEL_MAX     = 7'd100;
   localparam logic [6:0] LEVEL_DIM_MIN = 7'd5;
   localparam logic [15:0] DIM_MIN_SECONDS = 16'd5;

   // Parameter defaults
   localparam int TIMER_BITS_DEF = 16;
   localparam int DOZE_DELAY_DEF = 300;

   // Control of one countdown for the item being processed.
   typedef struct packed {
      logic tick;
      logic arm;
      logic disarm;
   } tmr_ctl_type;

   // Dimmed brightness: 30 percent of the level, floored at five.
   // level * 3 / 10 is done as a multiply by 205 / 2048, exact for levels up to 127.
   function automatic logic [6:0] dim_level(input logic [6:0] level);
      logic [8:0]  tripled;
      logic [16:0] scaled;
      logic [6:0]  quot;
      tripled = 9'(level) * 9'd3;
      scaled  = 17'(tripled) * 17'd205;
      quot    = 7'(scaled >> 11);
      return (quot < LEVEL_DIM_MIN) ? LEVEL_DIM_MIN : quot;
   endfunction

endpackage

[src/display_idle_power_controller_top.sv]
// Top level of the display idle power controller: handshake, state and result logic.

// The block keeps the display power state (active, dim, screen off, doze,
// suspended), the panel brightness, the saved brightness, a wakelock count and
// three second countdowns (dim, screen off, sleep). Each item on the req
// channel is one event: a one-second tick, user activity, a screen-off or
// screen-on request, or a write of the brightness or the lock count. Every
// item yields exactly one result on the rsp channel with the new state, the
// brightness, the previous state and the doze and suspend request pulses.
// Items are taken one per clock cycle as long as the rsp channel does not
// stall. An accepted item first lands in an input register; once the result
// register is free or being emptied, the whole state update is done in one
// pass and the result is registered. The input register lets a new item in
// while a result still waits on a stalled rsp channel. Configuration is
// written through the csr port at any edge with csr_we high and takes effect
// on the next processed item. Countdowns are TIMER_BITS wide; loaded lengths
// saturate at their largest count. There is no reset sweep: the block is
// ready right after reset.
module display_idle_power_controller_top #(
   parameter int TIMER_BITS         = dipc_pkg::TIMER_BITS_DEF,
   parameter int DOZE_DELAY_SECONDS = dipc_pkg::DOZE_DELAY_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input items
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,  // opcode[2:0], value[10:3]
   // Result items
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,  // power_state[2:0],
                                                       // brightness_level[9:3],
                                                       // state_changed[10],
                                                       // previous_state[13:11],
                                                       // doze_request[14],
                                                       // suspend_request[15]
   // Configuration writes
   input  logic                            csr_we,
   input  logic [dipc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dipc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int LOAD_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
   localparam logic [LOAD_W-1:0] TIMER_TOP = LOAD_W'({TIMER_BITS{1'b1}});

   // Saturate a 16-bit length to the countdown width.
   function automatic logic [TIMER_BITS-1:0] sat_load(input logic [15:0] n);
      logic [LOAD_W-1:0] wide;
      wide = LOAD_W'(n);
      return TIMER_BITS'((wide > TIMER_TOP) ? TIMER_TOP : wide);
   endfunction

   // Configuration registers
   logic [15:0] scr_to_ff, dim_to_ff, susp_dly_ff;
   logic        doze_en_ff, asusp_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_to_ff   <= dipc_pkg::SCREEN_TIMEOUT_RST;
         dim_to_ff   <= dipc_pkg::DIM_TIMEOUT_RST;
         doze_en_ff  <= dipc_pkg::DOZE_ENABLE_RST;
         asusp_en_ff <= dipc_pkg::AUTO_SUSPEND_RST;
         susp_dly_ff <= dipc_pkg::SUSPEND_DELAY_RST;
      end else if (csr_we) begin
         case (csr_index)
            dipc_pkg::REG_SCREEN_TIMEOUT: scr_to_ff   <= csr_wdata;
            dipc_pkg::REG_DIM_TIMEOUT:    dim_to_ff   <= csr_wdata;
            dipc_pkg::REG_DOZE_ENABLE:    doze_en_ff  <= csr_wdata[0];
            dipc_pkg::REG_AUTO_SUSPEND:   asusp_en_ff <= csr_wdata[0];
            dipc_pkg::REG_SUSPEND_DELAY:  susp_dly_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register and result register handshake. An item moves from the
   // input register into processing whenever the result register is empty
   // or is being drained in the same cycle.
   logic        in_vld_ff, in_vld_in;
   logic [2:0]  in_op_ff;
   logic [7:0]  in_val_ff;
   logic        out_vld_ff, out_vld_in;
   logic [15:0] out_data_ff;
   logic        proc_go;

   assign proc_go    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || proc_go;
   assign in_vld_in  = (req_tvalid && req_tready) || (in_vld_ff && !proc_go);
   assign out_vld_in = proc_go || (out_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff  <= req_tdata[2:0];
         in_val_ff <= req_tdata[10:3];
      end
   end

   // Power state registers
   logic [2:0] mode_ff, mode_in;
   logic [6:0] level_ff, level_in;
   logic [6:0] saved_ff, saved_in;
   logic [7:0] locks_ff, locks_in;
   logic       is_doze_ff, is_doze_in;

   // Countdown expiry flags and controls
   logic                   dim_fire, off_fire, slp_fire;
   dipc_pkg::tmr_ctl_type  dim_ctl, off_ctl, slp_ctl;
   logic [TIMER_BITS-1:0]  dim_load, off_load, slp_load;

   // Timer lengths derived from the configuration.
   logic signed [16:0] dim_len_s, remain_s;
   logic [15:0]        dim_len;
   logic               remain_pos;

   always_comb begin
      dim_len_s = (dim_to_ff != 16'd0) ? $signed({1'b0, dim_to_ff})
                                        : $signed({1'b0, scr_to_ff}) - 17'sd5;
      dim_len   = (dim_len_s < $signed({1'b0, dipc_pkg::DIM_MIN_SECONDS}))
                  ? dipc_pkg::DIM_MIN_SECONDS : dim_len_s[15:0];
      remain_s  = $signed({1'b0, scr_to_ff}) - $signed({1'b0, dim_to_ff});
      remain_pos = (remain_s > 17'sd0);
   end

   assign dim_load = sat_load(dim_len);
   assign off_load = sat_load(remain_s[15:0]);
   assign slp_load = doze_en_ff ? sat_load(16'(DOZE_DELAY_SECONDS)) : sat_load(susp_dly_ff);

   // Single pass state update for the item in the input register.
   logic       is_tick, restart, dim_act, off_do, slp_do, scr_off, slp_arm;
   logic       dz, sp;
   logic [6:0] lvl_mid;

   always_comb begin
      is_tick = proc_go && (in_op_ff == dipc_pkg::OP_TICK);
      restart = proc_go && ((in_op_ff == dipc_pkg::OP_ACTIVITY) ||
                            (in_op_ff == dipc_pkg::OP_SCREEN_ON));

      // Dim expiry only acts while active and unlocked.
      dim_act = is_tick && dim_fire && (mode_ff == dipc_pkg::ST_ACTIVE) && (locks_ff == 8'd0);
      // Re-arming the off countdown drops its expiry on this tick.
      off_do  = is_tick && off_fire && !(dim_act && remain_pos);
      scr_off = off_do || (proc_go && (in_op_ff == dipc_pkg::OP_SCREEN_OFF));
      // Screen off cancels the sleep countdown and its pending expiry.
      slp_do  = is_tick && slp_fire && !off_do;
      slp_arm = scr_off && (locks_ff == 8'd0) && (doze_en_ff || asusp_en_ff);

      mode_in    = mode_ff;
      level_in   = level_ff;
      saved_in   = saved_ff;
      locks_in   = locks_ff;
      is_doze_in = is_doze_ff;
      dz         = 1'b0;
      sp         = 1'b0;

      lvl_mid = dim_act ? dipc_pkg::dim_level(level_ff) : level_ff;
      if (dim_act) begin
         level_in = lvl_mid;
         mode_in  = dipc_pkg::ST_DIM;
      end
      if (scr_off) begin
         if (lvl_mid != 7'd0) begin
            saved_in = lvl_mid;
         end
         level_in = 7'd0;
         mode_in  = dipc_pkg::ST_OFF;
         if (slp_arm) begin
            is_doze_in = doze_en_ff;
         end
      end
      if (slp_do) begin
         if (is_doze_ff) begin
            mode_in = dipc_pkg::ST_DOZE;
            dz      = 1'b1;
         end else begin
            mode_in = dipc_pkg::ST_SUSP;
            sp      = 1'b1;
         end
      end

      if (proc_go) begin
         case (in_op_ff)
            dipc_pkg::OP_SCREEN_ON: begin
               level_in = (saved_ff != 7'd0) ? saved_ff : dipc_pkg::LEVEL_DEFAULT;
               mode_in  = dipc_pkg::ST_ACTIVE;
            end
            dipc_pkg::OP_SET_LEVEL: begin
               level_in = (in_val_ff > 8'(dipc_pkg::LEVEL_MAX)) ? dipc_pkg::LEVEL_MAX
                                                                 : in_val_ff[6:0];
            end
            dipc_pkg::OP_SET_LOCKS: locks_in = in_val_ff;
            default: ;
         endcase
      end

      dim_ctl.tick   = is_tick;
      dim_ctl.arm    = restart && (scr_to_ff != 16'd0);
      dim_ctl.disarm = restart;

      off_ctl.tick   = is_tick;
      off_ctl.arm    = dim_act && remain_pos;
      off_ctl.disarm = restart;

      slp_ctl.tick   = is_tick;
      slp_ctl.arm    = slp_arm;
      slp_ctl.disarm = restart || scr_off;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= dipc_pkg::ST_ACTIVE;
         level_ff   <= dipc_pkg::LEVEL_RST;
         saved_ff   <= 7'd0;
         locks_ff   <= 8'd0;
         is_doze_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         level_ff   <= level_in;
         saved_ff   <= saved_in;
         locks_ff   <= locks_in;
         is_doze_ff <= is_doze_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_go) begin
         out_data_ff <= {sp, dz, mode_ff, (mode_in != mode_ff), level_in, mode_in};
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   dipc_timer #(.TIMER_BITS(TIMER_BITS)) u_dim_timer (
      .clock      (clock),
      .reset      (reset),
      .ctl        (dim_ctl),
      .load_value (dim_load),
      .fire       (dim_fire)
   );

   dipc_timer #(.TIMER_BITS(TIMER_BITS)) u_off_timer (
      .clock      (clock),
      .reset      (reset),
      .ctl        (off_ctl),
      .load_value (off_load),
      .fire       (off_fire)
   );

   dipc_timer #(.TIMER_BITS(TIMER_BITS)) u_slp_timer (
      .clock      (clock),
      .reset      (reset),
      .ctl        (slp_ctl),
      .load_value (slp_load),
      .fire       (slp_fire)
   );

`ifndef SYNTHESIS
   // A result never carries both request pulses.
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[14] && rsp_tdata[15]))
      else $error("doze and suspend requested by one item");

   // A doze pulse reports the doze state, a suspend pulse the suspended state.
   a_request_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((!rsp_tdata[14] || rsp_tdata[2:0] == dipc_pkg::ST_DOZE) &&
                      (!rsp_tdata[15] || rsp_tdata[2:0] == dipc_pkg::ST_SUSP)))
      else $error("request pulse without matching power state");

   // The change flag agrees with the reported states.
   a_change_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[10] == (rsp_tdata[2:0] != rsp_tdata[13:11])))
      else $error("state_changed inconsistent with states");

   // Brightness stays within range.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (level_ff <= dipc_pkg::LEVEL_MAX) && (saved_ff <= dipc_pkg::LEVEL_MAX))
      else $error("brightness out of range");

   // A waiting item stays in the input register until it is processed.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !proc_go) |=> (in_vld_ff && $stable(in_op_ff) && $stable(in_val_ff)))
      else $error("input item lost while waiting");
`endif

endmodule

[src/dipc_timer.sv]
// One armed second countdown of the display idle power controller.
module dipc_timer #(
   parameter int TIMER_BITS = dipc_pkg::TIMER_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dipc_pkg::tmr_ctl_type ctl,
   input  logic [TIMER_BITS-1:0] load_value,
   output logic                  fire
);

   logic                  armed_ff, armed_in;
   logic [TIMER_BITS-1:0] count_ff, count_in;

   // Expires on the tick that finds a count of one or zero.
   assign fire = armed_ff && (count_ff <= TIMER_BITS'(1));

   always_comb begin
      armed_in = armed_ff;
      count_in = count_ff;
      if (ctl.tick && armed_ff) begin
         if (fire) begin
            armed_in = 1'b0;
            count_in = '0;
         end else begin
            count_in = count_ff - TIMER_BITS'(1);
         end
      end
      if (ctl.arm) begin
         armed_in = 1'b1;
         count_in = load_value;
      end else if (ctl.disarm) begin
         armed_in = 1'b0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         armed_ff <= armed_in;
         count_ff <= count_in;
      end
   end

endmodule

[sim/display_idle_power_controller_top_tb.sv]
// Self-checking testbench of the display idle power controller with a built-in predictor.
`timescale 1ns / 100ps

// The testbench drives event items (ticks, user activity, screen off and on,
// brightness and lock writes) into the req channel and checks every result on
// the rsp channel against a predictor of the controller held in a scoreboard
// class. Configuration is only written while nothing is in flight. After a
// short directed opening, eight random phases run with different register
// settings and different idling patterns on both sides of the block.
module display_idle_power_controller_top_tb;

   localparam int TIMER_BITS      = dipc_pkg::TIMER_BITS_DEF;
   localparam int DOZE_DELAY      = dipc_pkg::DOZE_DELAY_DEF;
   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 11;
   localparam int PHASE_COUNT     = 8;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int HOLD_CYCLES     = 200;
   localparam int SETTLE_CYCLES   = 10;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int MAX_REPORTS     = 40;

   // Opcodes that the block has to ignore.
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   // One result item as it sits in rsp_tdata, highest field first.
   typedef struct packed {
      logic       susp_req;
      logic       doze_req;
      logic [2:0] prev_state;
      logic       changed;
      logic [6:0] level;
      logic [2:0] state;
   } panel_result_type;

   typedef struct {
      bit     armed;
      longint count;
   } cdown_type;

   // Scoreboard: keeps its own copy of the controller state, predicts the
   // result of every accepted item and compares the results in order.
   class idle_scoreboard_type;
      panel_result_type expected_q[$];
      int               errors;
      int               results_seen;

      int         screen_to, dim_to, susp_delay;
      bit         doze_en, auto_susp;
      logic [2:0] mode;
      int         level, saved, locks;
      cdown_type  dim_cd, off_cd, sleep_cd;
      bit         sleep_doze;

      function new();
         screen_to  = int'(dipc_pkg::SCREEN_TIMEOUT_RST);
         dim_to     = int'(dipc_pkg::DIM_TIMEOUT_RST);
         doze_en    = dipc_pkg::DOZE_ENABLE_RST;
         auto_susp  = dipc_pkg::AUTO_SUSPEND_RST;
         susp_delay = int'(dipc_pkg::SUSPEND_DELAY_RST);
         mode       = dipc_pkg::ST_ACTIVE;
         level      = int'(dipc_pkg::LEVEL_RST);
         saved      = 0;
         locks      = 0;
         dim_cd     = '{0, 0};
         off_cd     = '{0, 0};
         sleep_cd   = '{0, 0};
         sleep_doze = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] data);
         case (idx)
            dipc_pkg::REG_SCREEN_TIMEOUT: screen_to  = int'(data);
            dipc_pkg::REG_DIM_TIMEOUT:    dim_to     = int'(data);
            dipc_pkg::REG_DOZE_ENABLE:    doze_en    = data[0];
            dipc_pkg::REG_AUTO_SUSPEND:   auto_susp  = data[0];
            dipc_pkg::REG_SUSPEND_DELAY:  susp_delay = int'(data);
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // A countdown loaded with n; lengths beyond the counter width saturate.
      function cdown_type loaded(longint n);
         cdown_type c;
         longint    top;
         top     = (longint'(1) << TIMER_BITS) - 1;
         c.armed = 1;
         c.count = (n > top) ? top : n;
         return c;
      endfunction

      // One second passes; returns 1 when the countdown runs out now.
      function bit count_down(inout cdown_type c);
         if (!c.armed) return 0;
         if (c.count <= 1) begin
            c = '{0, 0};
            return 1;
         end
         c.count--;
         return 0;
      endfunction

      function void restart_idle();
         int d;
         dim_cd   = '{0, 0};
         off_cd   = '{0, 0};
         sleep_cd = '{0, 0};
         if (screen_to == 0) return;
         d = dim_to;
         if (d <= 0) d = screen_to - 5;
         if (d < int'(dipc_pkg::DIM_MIN_SECONDS)) d = int'(dipc_pkg::DIM_MIN_SECONDS);
         dim_cd = loaded(d);
      endfunction

      function void blank_screen();
         if (level > 0) saved = level;
         level    = 0;
         mode     = dipc_pkg::ST_OFF;
         sleep_cd = '{0, 0};
         if (locks == 0) begin
            if (doze_en) begin
               sleep_cd   = loaded(DOZE_DELAY);
               sleep_doze = 1;
            end else if (auto_susp) begin
               sleep_cd   = loaded(susp_delay);
               sleep_doze = 0;
            end
         end
      endfunction

      function void note_item(logic [15:0] tdata);
         logic [2:0]       op;
         int               val;
         int               lv;
         int               remain;
         bit               fd, fo, fs;
         panel_result_type r;
         op          = tdata[2:0];
         val         = int'(tdata[10:3]);
         r           = '0;
         r.prev_state = mode;
         case (op)
            dipc_pkg::OP_TICK: begin
               fd = count_down(dim_cd);
               fo = count_down(off_cd);
               fs = count_down(sleep_cd);
               if (fd && mode == dipc_pkg::ST_ACTIVE && locks == 0) begin
                  lv = level * 30 / 100;
                  if (lv < int'(dipc_pkg::LEVEL_DIM_MIN)) lv = int'(dipc_pkg::LEVEL_DIM_MIN);
                  level  = lv;
                  mode   = dipc_pkg::ST_DIM;
                  remain = screen_to - dim_to;
                  if (remain > 0) begin
                     off_cd = loaded(remain);
                     fo     = 0;
                  end
               end
               if (fo) begin
                  blank_screen();
                  fs = 0;
               end
               if (fs) begin
                  if (sleep_doze) begin
                     mode       = dipc_pkg::ST_DOZE;
                     r.doze_req = 1'b1;
                  end else begin
                     mode       = dipc_pkg::ST_SUSP;
                     r.susp_req = 1'b1;
                  end
               end
            end
            dipc_pkg::OP_ACTIVITY:   restart_idle();
            dipc_pkg::OP_SCREEN_OFF: blank_screen();
            dipc_pkg::OP_SCREEN_ON: begin
               level = (saved > 0) ? saved : int'(dipc_pkg::LEVEL_DEFAULT);
               mode  = dipc_pkg::ST_ACTIVE;
               restart_idle();
            end
            dipc_pkg::OP_SET_LEVEL:
               level = (val > int'(dipc_pkg::LEVEL_MAX)) ? int'(dipc_pkg::LEVEL_MAX) : val;
            dipc_pkg::OP_SET_LOCKS: locks = val;
            default: ;
         endcase
         r.state   = mode;
         r.level   = 7'(level);
         r.changed = (mode != r.prev_state);
         expected_q.push_back(r);
      endfunction

      task report(string what, int got, int want);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("[%0t] result %0d: %s is %0d, expected %0d",
                     $realtime, results_seen, what, got, want);
      endtask

      task check_result(logic [15:0] tdata);
         panel_result_type got, want;
         got = tdata;
         results_seen++;
         if (expected_q.size() == 0) begin
            report("unexpected result, data", int'(tdata), 0);
            return;
         end
         want = expected_q.pop_front();
         if (got.state != want.state)
            report("power_state", int'(got.state), int'(want.state));
         if (got.level != want.level)
            report("brightness_level", int'(got.level), int'(want.level));
         if (got.changed != want.changed)
            report("state_changed", int'(got.changed), int'(want.changed));
         if (got.prev_state != want.prev_state)
            report("previous_state", int'(got.prev_state), int'(want.prev_state));
         if (got.doze_req != want.doze_req)
            report("doze_request", int'(got.doze_req), int'(want.doze_req));
         if (got.susp_req != want.susp_req)
            report("suspend_request", int'(got.susp_req), int'(want.susp_req));
      endtask
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [15:0]                      req_tdata;   // opcode[2:0], value[10:3]
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [15:0]                      rsp_tdata;   // power_state[2:0], brightness_level[9:3],
                                                  // state_changed[10], previous_state[13:11],
                                                  // doze_request[14], suspend_request[15]
   logic                             csr_we;
   logic [dipc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [dipc_pkg::CSR_DATA_W-1:0]  csr_wdata;

   idle_scoreboard_type sb = new();

   // Idling controls, set by the stimulus process and read by the drivers.
   int gap_pct;
   int stall_pct;
   int hold_req;
   int burst_left;
   int cycle_count;

   // Register settings of the random phases: small timeouts so that the
   // countdowns run out often, plus the disabled and the largest values.
   int setting_screen[PHASE_COUNT] = '{8, 6, 0, 4, 65535, 12, 3, 10};
   int setting_dim[PHASE_COUNT]    = '{3, 0, 5, 9, 65535, 0, 2, 0};
   bit setting_doze[PHASE_COUNT]   = '{0, 1, 0, 0, 1, 0, 1, 0};
   bit setting_auto[PHASE_COUNT]   = '{1, 0, 1, 0, 1, 1, 1, 1};
   int setting_delay[PHASE_COUNT]  = '{4, 2, 0, 65535, 65535, 1, 0, 3};

   display_idle_power_controller_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Both handshakes are observed at the rising edge, before any register of
   // the block or of the testbench takes its new value, so the sampled
   // signals are the ones that decided the transfer. The input side is
   // handled first so that an item is always known before its result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_item(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   // Result side. A hold request makes the receiver refuse results for a
   // long stretch that it counts itself; otherwise it stalls at random.
   always @(posedge clock) begin
      int hold_seen;
      int hold_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_seen = hold_req;
         hold_left = 0;
      end else begin
         if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (int'($urandom_range(99)) >= stall_pct);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Offers one item and returns at the edge where it is accepted. The valid
   // stays high on return so back-to-back items follow without a gap.
   task automatic send_item(logic [2:0] op, logic [7:0] val);
      while (gap_pct != 0 && int'($urandom_range(99)) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, val, op};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering items and waits until every result has come back. The
   // first edge is always awaited so that the last accepted item is counted.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, int data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(data);
      sb.write_reg(idx, 16'(data));
      @(posedge clock);
   endtask

   task automatic apply_setting(int p);
      write_reg(dipc_pkg::REG_SCREEN_TIMEOUT, setting_screen[p]);
      write_reg(dipc_pkg::REG_DIM_TIMEOUT, setting_dim[p]);
      write_reg(dipc_pkg::REG_DOZE_ENABLE, int'(setting_doze[p]));
      write_reg(dipc_pkg::REG_AUTO_SUSPEND, int'(setting_auto[p]));
      write_reg(dipc_pkg::REG_SUSPEND_DELAY, setting_delay[p]);
      csr_we <= 1'b0;
   endtask

   // Picks the next random item. Ticks dominate and often come in bursts so
   // that the countdowns actually run out; a burst is occasionally set near
   // the doze delay in length.
   task automatic next_item(output logic [2:0] op, output logic [7:0] val);
      int r;
      val = 8'($urandom);
      if (burst_left > 0) begin
         burst_left--;
         op = dipc_pkg::OP_TICK;
         return;
      end
      r = int'($urandom_range(99));
      if (r < 45) begin
         op = dipc_pkg::OP_TICK;
      end else if (r < 55) begin
         op = dipc_pkg::OP_ACTIVITY;
      end else if (r < 62) begin
         op = dipc_pkg::OP_SCREEN_OFF;
      end else if (r < 69) begin
         op = dipc_pkg::OP_SCREEN_ON;
      end else if (r < 79) begin
         op = dipc_pkg::OP_SET_LEVEL;
         if ($urandom_range(3) != 0) val = 8'($urandom_range(100));
      end else if (r < 89) begin
         // Locks are mostly released, or nothing would ever dim or sleep.
         op = dipc_pkg::OP_SET_LOCKS;
         if ($urandom_range(9) < 7) val = 8'd0;
      end else if (r < 93) begin
         op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
      end else begin
         op         = dipc_pkg::OP_TICK;
         burst_left = ($urandom_range(5) == 0) ? int'($urandom_range(290, 310))
                                               : int'($urandom_range(2, 40));
      end
   endtask

   // One random phase. With doze enabled it opens with a lock release, a screen
   // off and a tick run of DOZE_DELAY + 5 items that the phase length cuts short.
   // A third of the way in the receiver holds off for a long stretch while items
   // keep coming, and two thirds in the sender pauses until the block has returned every result.
   task automatic run_phase(int n, bit doze_lead);
      logic [2:0] op;
      logic [7:0] val;
      int         i;
      i          = 0;
      burst_left = 0;
      if (doze_lead) begin
         send_item(dipc_pkg::OP_SET_LOCKS, 8'd0);
         send_item(dipc_pkg::OP_SCREEN_OFF, 8'($urandom));
         burst_left = DOZE_DELAY + 5;
         i = 2;
      end
      while (i < n) begin
         if (i == n / 3) hold_req++;
         if (i == 2 * n / 3) wait_drained();
         next_item(op, val);
         send_item(op, val);
         i++;
      end
   endtask

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      gap_pct    = 0;
      stall_pct  = 0;
      hold_req   = 0;
      burst_left = 0;
      cycle_count = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening at the reset settings: ignored opcodes, screen on
      // with nothing saved, brightness extremes and saturation, screen off
      // with the panel already dark, lock count extremes.
      send_item(OP_SPARE_A, 8'hFF);
      send_item(OP_SPARE_B, 8'h00);
      send_item(dipc_pkg::OP_SCREEN_ON, 8'h55);
      send_item(dipc_pkg::OP_SET_LEVEL, 8'd0);
      send_item(dipc_pkg::OP_SET_LEVEL, 8'd100);
      send_item(dipc_pkg::OP_SET_LEVEL, 8'd101);
      send_item(dipc_pkg::OP_SET_LEVEL, 8'd255);
      send_item(dipc_pkg::OP_SET_LEVEL, 8'd3);
      send_item(dipc_pkg::OP_SCREEN_OFF, 8'h00);
      send_item(dipc_pkg::OP_SET_LEVEL, 8'd0);
      send_item(dipc_pkg::OP_SCREEN_OFF, 8'hFF);
      send_item(dipc_pkg::OP_SCREEN_ON, 8'h0F);
      send_item(dipc_pkg::OP_SET_LOCKS, 8'd255);
      send_item(dipc_pkg::OP_ACTIVITY, 8'hF0);
      send_item(dipc_pkg::OP_TICK, 8'h00);
      send_item(dipc_pkg::OP_SET_LOCKS, 8'd0);
      send_item(dipc_pkg::OP_TICK, 8'hFF);
      send_item(dipc_pkg::OP_SET_LEVEL, 8'd127);
      send_item(dipc_pkg::OP_SCREEN_OFF, 8'hAA);
      send_item(dipc_pkg::OP_TICK, 8'h55);
      send_item(dipc_pkg::OP_SCREEN_ON, 8'h01);
      send_item(dipc_pkg::OP_ACTIVITY, 8'h80);
      send_item(dipc_pkg::OP_SET_LOCKS, 8'd1);
      send_item(dipc_pkg::OP_SET_LOCKS, 8'd0);

      // Random phases. The idling pattern rotates: none, sender idle about
      // half the time, receiver stalling about half the time, both at times.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_drained();
         apply_setting(p);
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 52; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 52; end
            default: begin gap_pct = 29; stall_pct = 29; end
         endcase
         run_phase(ITEMS_PER_PHASE, setting_doze[p]);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0) sb.report("results never returned", 0, sb.pending());
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
